// ----- hdl/matrix_max_path_sum_top_assert.svh -----
// Assertion macros for the checker of the matrix path sum block.
`ifndef MATRIX_MAX_PATH_SUM_TOP_ASSERT_SVH
`define MATRIX_MAX_PATH_SUM_TOP_ASSERT_SVH

// Checked on every rising edge of clk, switched off while reset is asserted.
`define MMPS_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MMPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mmps_pkg.sv -----
// Package of the matrix path sum block: sizes, sum type, saturation and cell control.
package mmps_pkg;

	localparam int MAX_SIZE = 64;
	localparam int VAL_W    = 16;
	localparam int SIZE_W   = 7;
	localparam int SUM_W    = 22;
	localparam int CNT_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int N_W      = CNT_W + 1;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [N_W-1:0]          n_t;
	typedef logic [SIZE_W-1:0]       size_t;

	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

	// Control shared by every cell of the column chain.
	typedef struct packed {
		logic shift;       // a cell beat was accepted
		logic from_static; // refill the read chain from the column sums
	} cell_ctrl_t;

	function automatic sum_t sat_sum(input logic signed [SUM_W:0] x);
		sum_t r;
		if (x[SUM_W] != x[SUM_W-1]) begin
			r = x[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			r = x[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/mmps_cell.sv -----
// One column cell: the stored path sum of its column and one stage of the read chain.
module mmps_cell
	import mmps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       wr_en,
	input  sum_t       wr_data,
	input  sum_t       nb_col_sum,
	input  sum_t       nb_shadow,
	output sum_t       col_sum,
	output sum_t       shadow
);

	sum_t col_sum_q;
	sum_t shadow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_sum_q <= '0;
		end else if (wr_en) begin
			col_sum_q <= wr_data;
		end
	end

	// The read chain moves one column towards cell 0 per beat. On a column 0
	// beat it is reloaded from the right-hand neighbour's column sum, so that
	// cell 0 then holds column 1 of the previous row.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			shadow_q <= ctrl.from_static ? nb_col_sum : nb_shadow;
		end
	end

	assign col_sum = col_sum_q;
	assign shadow  = shadow_q;

endmodule

// ----- hdl/matrix_max_path_sum_top.sv -----
// Top level of the matrix maximum path sum block.
//
// Cells of a square matrix enter on the input channel (in_valid/in_ready) in
// row-major order, one beat per cell: cell_value plus start_matrix, which marks
// the first cell of a new matrix. The matrix size comes from cfg_wr_data,
// written with cfg_wr_en while no matrix is in flight; 0 acts as 1 and values
// above 64 act as 64.
// The block takes one cell per cycle while in_ready is high. Each cell's path
// sum is formed in the cycle it is accepted, from a chain of 64 column cells
// that keeps the previous row's sums lined up at fixed taps. On the last cell
// of a matrix the best path sum of the bottom row appears on best_path_sum
// (out_valid/out_ready) in the next cycle; no other beat produces a result.
// The result sits in an output register. While it waits for the receiver, in_ready
// stays high if out_ready is high and drops only while the register is full and
// stalled, so a waiting result is never overwritten.
// Reset clears all column sums to zero, the position to row 0, column 0, the
// running maximum to the most negative value and the matrix size to 64.
module matrix_max_path_sum_top
	import mmps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  size_t       cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  val_t        cell_value,
	input  logic        start_matrix,
	output logic        out_valid,
	input  logic        out_ready,
	output sum_t        best_path_sum
);

	size_t      size_q;
	cnt_t       row_q;
	cnt_t       col_q;
	sum_t       best_q;
	sum_t       left_q;
	logic       out_valid_q;
	sum_t       best_path_sum_q;

	n_t         n_eff;
	n_t         row_a, col_a, row_b, col_b, row_c, col_c;
	logic       restart;
	cnt_t       col;
	logic       first_row, last_row, final_cell, col_wrap;
	sum_t       best_base, best_new;
	sum_t       above, up_right, m1, m2, sum_new;
	logic       left_ok, ur_ok;
	logic       acc;
	n_t         col_inc;
	cell_ctrl_t ctrl;

	sum_t       col_sum_w [MAX_SIZE+1];
	sum_t       shadow_w  [MAX_SIZE+1];

	assign acc      = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	always_comb begin
		if (size_q == '0) begin
			n_eff = N_W'(1);
		end else if (int'(size_q) > MAX_SIZE) begin
			n_eff = N_W'(MAX_SIZE);
		end else begin
			n_eff = N_W'(size_q);
		end
	end

	// Position of this cell, including the wrap cases after a size change.
	always_comb begin
		row_a = start_matrix ? '0 : N_W'(row_q);
		col_a = start_matrix ? '0 : N_W'(col_q);
		if (col_a >= n_eff) begin
			col_b = '0;
			row_b = row_a + N_W'(1);
		end else begin
			col_b = col_a;
			row_b = row_a;
		end
		restart = 1'b0;
		row_c   = row_b;
		col_c   = col_b;
		if (row_b >= n_eff) begin
			row_c   = '0;
			col_c   = '0;
			restart = 1'b1;
		end
		col        = col_c[CNT_W-1:0];
		first_row  = (row_c == '0);
		last_row   = (row_c == n_eff - N_W'(1));
		final_cell = last_row && (col_c == n_eff - N_W'(1));
		col_inc    = col_c + N_W'(1);
		col_wrap   = (col_inc >= n_eff);
		best_base  = (start_matrix || restart) ? SUM_MIN : best_q;
	end

	// Column 0 reads the stored sums directly; later columns read the chain.
	always_comb begin
		above    = (col == '0) ? col_sum_w[0] : shadow_w[0];
		up_right = (col == '0) ? col_sum_w[1] : shadow_w[1];
		left_ok  = (col != '0);
		ur_ok    = !col_wrap;
		m1       = (left_ok && (left_q > above)) ? left_q : above;
		m2       = (ur_ok && (up_right > m1)) ? up_right : m1;
		if (first_row) begin
			sum_new = SUM_W'(cell_value);
		end else begin
			sum_new = sat_sum((SUM_W+1)'(cell_value) + (SUM_W+1)'(m2));
		end
		best_new = (last_row && (sum_new > best_base)) ? sum_new : best_base;
	end

	assign ctrl.shift       = acc;
	assign ctrl.from_static = (col == '0);

	assign col_sum_w[MAX_SIZE] = '0;
	assign shadow_w[MAX_SIZE]  = '0;

	for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
		mmps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.wr_en      (acc && (col == CNT_W'(i))),
			.wr_data    (sum_new),
			.nb_col_sum (col_sum_w[i+1]),
			.nb_shadow  (shadow_w[i+1]),
			.col_sum    (col_sum_w[i]),
			.shadow     (shadow_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= size_t'(MAX_SIZE);
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			best_q <= SUM_MIN;
		end else if (acc) begin
			if (final_cell) begin
				row_q  <= '0;
				col_q  <= '0;
				best_q <= SUM_MIN;
			end else if (col_wrap) begin
				row_q  <= CNT_W'(row_c + N_W'(1));
				col_q  <= '0;
				best_q <= best_new;
			end else begin
				row_q  <= CNT_W'(row_c);
				col_q  <= CNT_W'(col_inc);
				best_q <= best_new;
			end
		end
	end

	// Up-left neighbour: the previous cell's value from above.
	always_ff @(posedge clk) begin
		if (acc && !first_row) begin
			left_q <= above;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && final_cell) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && final_cell) begin
			best_path_sum_q <= best_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_path_sum = best_path_sum_q;

endmodule

// ----- hdl/mmps_checker.sv -----
// Port-level checker of the matrix path sum block, bound to its top level.
`include "matrix_max_path_sum_top_assert.svh"

module mmps_checker
	import mmps_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input sum_t  best_path_sum
);

	// A stalled result keeps its value.
	`MMPS_ASSERT_CLK(a_out_hold,
		out_valid && !out_ready |=> out_valid && $stable(best_path_sum),
		"result changed while stalled")

	// With the output register empty the block is always ready for a cell.
	`MMPS_ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready,
		"input stalled with empty output")

	// A full, stalled output register blocks the input so no result is lost.
	`MMPS_ASSERT_CLK(a_no_overwrite, out_valid && !out_ready |-> !in_ready,
		"input taken over a waiting result")

	// A result only appears after a cell beat.
	`MMPS_ASSERT_CLK(a_result_cause, $rose(out_valid) |-> $past(in_valid && in_ready),
		"result without a cell beat")

	// Once reset has been held over a clock edge, nothing is offered.
	`MMPS_ASSERT_ALWAYS(a_reset_quiet, !arst_n && $past(!arst_n) |-> !out_valid,
		"result during reset")

endmodule

bind matrix_max_path_sum_top mmps_checker u_mmps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.best_path_sum (best_path_sum)
);
